FILE: rtl/rtpd_pkg.sv
// ----------------------------------------------------------------------------
// rtpd_pkg
// Shared types and constants of the RTP H.264 depacketizer.
// ----------------------------------------------------------------------------
`default_nettype none

package rtpd_pkg;

   localparam int LENGTH_BITS = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   localparam logic [4:0] NAL_SINGLE_MIN = 5'd1;
   localparam logic [4:0] NAL_SINGLE_MAX = 5'd12;
   localparam logic [4:0] NAL_STAP_A     = 5'd24;
   localparam logic [4:0] NAL_FU_A       = 5'd28;

   typedef enum logic [2:0] {
      ST_DATA    = 3'd0,
      ST_END     = 3'd1,
      ST_UNSUP   = 3'd2,
      ST_ORPHAN  = 3'd3,
      ST_OVERRUN = 3'd4,
      ST_ABANDON = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] nal_byte;
      logic       nal_first;
      logic       nal_last;
      status_type status;
   } res_type;

   // one queue entry: one or two results caused by one input beat
   typedef struct packed {
      logic    two;
      res_type res0;
      res_type res1;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   function automatic res_type mk_res(logic [7:0] b, logic first, logic last,
                                      status_type st);
      res_type r;
      r.nal_byte  = b;
      r.nal_first = first;
      r.nal_last  = last;
      r.status    = st;
      return r;
   endfunction

   function automatic res_type mk_status(status_type st);
      return mk_res(8'd0, 1'b0, 1'b0, st);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/rtpd_req_if.sv
// ----------------------------------------------------------------------------
// rtpd_req_if
// Payload byte channel: valid/ready with one payload byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       packet_end;

   modport source (output valid, output payload_byte, output packet_end, input ready);
   modport sink   (input valid, input payload_byte, input packet_end, output ready);
endinterface

`default_nettype wire

FILE: rtl/rtpd_rsp_if.sv
// ----------------------------------------------------------------------------
// rtpd_rsp_if
// NAL byte channel: valid/ready with one result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtpd_rsp_if;
   logic                 valid;
   logic                 ready;
   logic [7:0]           nal_byte;
   logic                 nal_first;
   logic                 nal_last;
   rtpd_pkg::status_type status;

   modport source (output valid, output nal_byte, output nal_first, output nal_last,
                   output status, input ready);
   modport sink   (input valid, input nal_byte, input nal_first, input nal_last,
                   input status, output ready);
endinterface

`default_nettype wire

FILE: rtl/rtpd_front.sv
// ----------------------------------------------------------------------------
// rtpd_front
// Payload parser: tracks packet/STAP-A/FU-A state and pushes the results of
// each accepted beat into the queue as one entry.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpd_front (
   input  wire                    clock,
   input  wire                    reset,
   rtpd_req_if.sink               req,
   input  rtpd_pkg::q_stat_type   q_stat,
   output logic                   push,
   output rtpd_pkg::entry_type    entry
);

   typedef enum logic [2:0] {
      PH_HEADER   = 3'd0,
      PH_SINGLE   = 3'd1,
      PH_LEN_HI   = 3'd2,
      PH_LEN_LO   = 3'd3,
      PH_INNER_HD = 3'd4,
      PH_INNER    = 3'd5,
      PH_FU_HDR   = 3'd6,
      PH_FU_BODY  = 3'd7
   } phase_type;

   localparam logic [16:0] LEN_MAX = 17'((1 << rtpd_pkg::LENGTH_BITS) - 1);

   phase_type                          phase_ff, phase_in;
   logic [rtpd_pkg::LENGTH_BITS-1:0]   bytes_left_ff, bytes_left_in;
   logic [7:0]                         length_high_ff, length_high_in;
   logic [2:0]                         indicator_ff, indicator_in;
   logic                               frag_open_ff, frag_open_in;
   logic                               frag_end_ff, frag_end_in;

   logic                               accept;
   logic [7:0]                         b;
   logic                               pend;
   logic [4:0]                         t;
   logic                               single_t;
   logic [16:0]                        len;
   logic [rtpd_pkg::LENGTH_BITS-1:0]   dec;
   logic                               pv, mv, sv;
   rtpd_pkg::res_type                  p_res, m_res, s_res;

   assign req.ready = !q_stat.full;
   assign accept    = req.valid && req.ready;
   assign b         = req.payload_byte;
   assign pend      = req.packet_end;
   assign t         = b[4:0];
   assign single_t  = (t >= rtpd_pkg::NAL_SINGLE_MIN) && (t <= rtpd_pkg::NAL_SINGLE_MAX);
   assign len       = {1'b0, length_high_ff, b};
   assign dec       = bytes_left_ff - rtpd_pkg::LENGTH_BITS'(1);

   always_comb begin
      phase_in       = phase_ff;
      bytes_left_in  = bytes_left_ff;
      length_high_in = length_high_ff;
      indicator_in   = indicator_ff;
      frag_open_in   = frag_open_ff;
      frag_end_in    = frag_end_ff;
      pv             = 1'b0;
      mv             = 1'b0;
      sv             = 1'b0;
      p_res          = rtpd_pkg::mk_status(rtpd_pkg::ST_ABANDON);
      m_res          = rtpd_pkg::mk_status(rtpd_pkg::ST_DATA);
      s_res          = rtpd_pkg::mk_status(rtpd_pkg::ST_OVERRUN);
      unique case (phase_ff)
         PH_HEADER: begin
            if (single_t) begin
               pv           = frag_open_ff;
               frag_open_in = 1'b0;
               frag_end_in  = 1'b0;
               mv           = 1'b1;
               m_res        = rtpd_pkg::mk_res(b, 1'b1, pend, rtpd_pkg::ST_DATA);
               phase_in     = pend ? PH_HEADER : PH_SINGLE;
            end else if (t == rtpd_pkg::NAL_STAP_A) begin
               pv           = frag_open_ff;
               frag_open_in = 1'b0;
               frag_end_in  = 1'b0;
               mv           = pend;
               m_res        = rtpd_pkg::mk_status(rtpd_pkg::ST_OVERRUN);
               phase_in     = pend ? PH_HEADER : PH_LEN_HI;
            end else if (t == rtpd_pkg::NAL_FU_A) begin
               mv    = pend;
               m_res = rtpd_pkg::mk_status(rtpd_pkg::ST_OVERRUN);
               if (pend) begin
                  phase_in = PH_HEADER;
               end else begin
                  indicator_in = b[7:5];
                  phase_in     = PH_FU_HDR;
               end
            end else begin
               pv           = frag_open_ff;
               frag_open_in = 1'b0;
               frag_end_in  = 1'b0;
               mv           = 1'b1;
               m_res        = rtpd_pkg::mk_status(rtpd_pkg::ST_UNSUP);
               phase_in     = pend ? PH_HEADER : PH_FU_BODY;
            end
         end
         PH_SINGLE: begin
            mv       = 1'b1;
            m_res    = rtpd_pkg::mk_res(b, 1'b0, pend, rtpd_pkg::ST_DATA);
            phase_in = pend ? PH_HEADER : PH_SINGLE;
         end
         PH_LEN_HI: begin
            length_high_in = b;
            mv             = pend;
            m_res          = rtpd_pkg::mk_status(rtpd_pkg::ST_OVERRUN);
            phase_in       = pend ? PH_HEADER : PH_LEN_LO;
         end
         PH_LEN_LO: begin
            m_res = rtpd_pkg::mk_status(rtpd_pkg::ST_OVERRUN);
            if (len > LEN_MAX) begin
               mv       = 1'b1;
               phase_in = pend ? PH_HEADER : PH_FU_BODY;
            end else if (len == 17'd0) begin
               phase_in = pend ? PH_HEADER : PH_LEN_HI;
            end else if (pend) begin
               mv       = 1'b1;
               phase_in = PH_HEADER;
            end else begin
               bytes_left_in = len[rtpd_pkg::LENGTH_BITS-1:0];
               phase_in      = PH_INNER_HD;
            end
         end
         PH_INNER_HD, PH_INNER: begin
            if (phase_ff == PH_INNER_HD && !single_t) begin
               mv       = 1'b1;
               m_res    = rtpd_pkg::mk_status(rtpd_pkg::ST_UNSUP);
               phase_in = pend ? PH_HEADER : PH_FU_BODY;
            end else begin
               bytes_left_in = dec;
               mv            = 1'b1;
               m_res         = rtpd_pkg::mk_res(b, phase_ff == PH_INNER_HD,
                                                dec == '0, rtpd_pkg::ST_DATA);
               if (dec == '0) begin
                  phase_in = pend ? PH_HEADER : PH_LEN_HI;
               end else if (pend) begin
                  sv       = 1'b1;
                  phase_in = PH_HEADER;
               end else begin
                  phase_in = PH_INNER;
               end
            end
         end
         PH_FU_HDR: begin
            if (b[7]) begin
               pv           = frag_open_ff;
               mv           = 1'b1;
               m_res        = rtpd_pkg::mk_res({indicator_ff, t}, 1'b1, 1'b0,
                                               rtpd_pkg::ST_DATA);
               frag_open_in = 1'b1;
               frag_end_in  = 1'b0;
            end else if (!frag_open_ff) begin
               mv    = 1'b1;
               m_res = rtpd_pkg::mk_status(rtpd_pkg::ST_ORPHAN);
            end else begin
               frag_end_in = b[6];
               if (pend && b[6]) begin
                  mv           = 1'b1;
                  m_res        = rtpd_pkg::mk_res(8'd0, 1'b0, 1'b1, rtpd_pkg::ST_END);
                  frag_open_in = 1'b0;
               end
            end
            if (pend) begin
               frag_end_in = 1'b0;
            end
            phase_in = pend ? PH_HEADER : PH_FU_BODY;
         end
         PH_FU_BODY: begin
            if (frag_open_ff) begin
               mv    = 1'b1;
               m_res = rtpd_pkg::mk_res(b, 1'b0, pend && frag_end_ff, rtpd_pkg::ST_DATA);
               if (pend && frag_end_ff) begin
                  frag_open_in = 1'b0;
               end
            end
            if (pend) begin
               frag_end_in = 1'b0;
               phase_in    = PH_HEADER;
            end
         end
         default: begin
            phase_in = PH_HEADER;
         end
      endcase
   end

   always_comb begin
      push = accept && (pv || mv);
      if (pv) begin
         entry.res0 = p_res;
         entry.res1 = m_res;
         entry.two  = mv;
      end else begin
         entry.res0 = m_res;
         entry.res1 = s_res;
         entry.two  = sv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HEADER;
         bytes_left_ff  <= '0;
         length_high_ff <= '0;
         indicator_ff   <= '0;
         frag_open_ff   <= 1'b0;
         frag_end_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         bytes_left_ff  <= bytes_left_in;
         length_high_ff <= length_high_in;
         indicator_ff   <= indicator_in;
         frag_open_ff   <= frag_open_in;
         frag_end_ff    <= frag_end_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/rtpd_queue.sv
// ----------------------------------------------------------------------------
// rtpd_queue
// Short FIFO of result entries between the parser and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpd_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  rtpd_pkg::entry_type    wr_entry,
   input  wire                    pop,
   output rtpd_pkg::entry_type    rd_entry,
   output rtpd_pkg::q_stat_type   q_stat
);

   rtpd_pkg::entry_type              mem_ff [rtpd_pkg::QUEUE_DEPTH];
   logic [rtpd_pkg::QPTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [rtpd_pkg::QPTR_BITS:0]     count_ff, count_in;
   logic                             do_push, do_pop;

   assign q_stat.full  = (count_ff == (rtpd_pkg::QPTR_BITS + 1)'(rtpd_pkg::QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign do_push      = push && !q_stat.full;
   assign do_pop       = pop && !q_stat.empty;
   assign rd_entry     = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == rtpd_pkg::QPTR_BITS'(rtpd_pkg::QUEUE_DEPTH - 1))
                         ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == rtpd_pkg::QPTR_BITS'(rtpd_pkg::QUEUE_DEPTH - 1))
                         ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/rtpd_back.sv
// ----------------------------------------------------------------------------
// rtpd_back
// Output stage: splits queue entries into single results and holds each in
// the output register until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpd_back (
   input  wire                    clock,
   input  wire                    reset,
   input  rtpd_pkg::entry_type    rd_entry,
   input  rtpd_pkg::q_stat_type   q_stat,
   output logic                   pop,
   rtpd_rsp_if.source             rsp
);

   logic               rsp_valid_ff;
   rtpd_pkg::res_type  res_ff, res_in;
   logic               sub_ff, sub_in;
   logic               load;

   assign load   = !rsp_valid_ff || rsp.ready;
   assign pop    = load && !q_stat.empty && (sub_ff || !rd_entry.two);
   assign res_in = sub_ff ? rd_entry.res1 : rd_entry.res0;
   assign sub_in = load && !q_stat.empty ? !pop : sub_ff;

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.nal_byte  = res_ff.nal_byte;
   assign rsp.nal_first = res_ff.nal_first;
   assign rsp.nal_last  = res_ff.nal_last;
   assign rsp.status    = res_ff.status;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sub_ff       <= 1'b0;
      end else begin
         if (load) begin
            rsp_valid_ff <= !q_stat.empty;
         end
         sub_ff <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && !q_stat.empty) begin
         res_ff <= res_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/rtp_h264_depacketizer.sv
// ----------------------------------------------------------------------------
// rtp_h264_depacketizer
// RTP H.264 payload depacketizer for single NAL, STAP-A and FU-A packets.
//
// req_ch carries one RTP payload byte per beat, packet_end high on the last
// byte of each packet. rsp_ch carries one result per beat: a NAL byte with
// first/last marks (status 0), a bare end marker (status 1) or an error
// status. A payload byte causes zero, one or two results.
// Each result passes through the queue and then the output register.
// Throughput: one byte per cycle; a byte with two results holds the output
// for both of them, which a four-entry queue between parser and output
// register absorbs. The parser stalls only when that queue is full.
// A stalled receiver holds the output register; bytes keep being accepted
// until the queue fills.
// Synchronous reset returns the parser to the payload header, closes any
// open fragment and empties the queue and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_h264_depacketizer (
   input  wire        clock,
   input  wire        reset,
   rtpd_req_if.sink   req_ch,
   rtpd_rsp_if.source rsp_ch
);

   logic                  push, pop;
   rtpd_pkg::entry_type   wr_entry, rd_entry;
   rtpd_pkg::q_stat_type  q_stat;

   rtpd_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_ch),
      .q_stat (q_stat),
      .push   (push),
      .entry  (wr_entry)
   );

   rtpd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .wr_entry (wr_entry),
      .pop      (pop),
      .rd_entry (rd_entry),
      .q_stat   (q_stat)
   );

   rtpd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .rd_entry (rd_entry),
      .q_stat   (q_stat),
      .pop      (pop),
      .rsp      (rsp_ch)
   );

endmodule

`default_nettype wire

FILE: rtl/rtpd_checker.sv
// ----------------------------------------------------------------------------
// rtpd_checker
// Port-level checks on the result channel of the depacketizer.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpd_checker (
   input wire                  clock,
   input wire                  reset,
   input wire                  rsp_valid,
   input wire                  rsp_ready,
   input wire [7:0]            rsp_nal_byte,
   input wire                  rsp_nal_first,
   input wire                  rsp_nal_last,
   input rtpd_pkg::status_type rsp_status
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_nal_byte)
         && $stable(rsp_nal_first) && $stable(rsp_nal_last) && $stable(rsp_status))
      else $error("stalled result changed");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != rtpd_pkg::ST_DATA && rsp_status != rtpd_pkg::ST_END
         |-> rsp_nal_byte == 8'd0 && !rsp_nal_first && !rsp_nal_last)
      else $error("error status carries data");

   a_end_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == rtpd_pkg::ST_END
         |-> rsp_nal_last && !rsp_nal_first && rsp_nal_byte == 8'd0)
      else $error("bad end marker");

endmodule

bind rtp_h264_depacketizer rtpd_checker u_rtpd_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_nal_byte  (rsp_ch.nal_byte),
   .rsp_nal_first (rsp_ch.nal_first),
   .rsp_nal_last  (rsp_ch.nal_last),
   .rsp_status    (rsp_ch.status)
);

`default_nettype wire

FILE: verif/nal_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nal_stream_checker
// Watches the payload and NAL channels of the depacketizer, rebuilds the
// expected NAL beats from every accepted payload beat and compares each
// result beat, field by field, with the oldest one still owed.
// ----------------------------------------------------------------------------
module nal_stream_checker
   import rtpd_pkg::*;
(
   input  logic clock,
   input  logic reset,
   rtpd_req_if  req_ch,
   rtpd_rsp_if  rsp_ch,
   output int   fails,
   output int   outstanding
);

   typedef enum logic [2:0] {
      AT_HEADER,
      IN_SINGLE,
      LEN_HIGH,
      LEN_LOW,
      INNER_HEAD,
      INNER_BODY,
      FU_HEAD,
      FU_BODY
   } parse_phase_type;

   parse_phase_type phase;
   logic [15:0]  left;
   logic [7:0]   len_high;
   logic [2:0]   nri_bits;
   logic         frag_open;
   logic         frag_ending;
   res_type      nal_expected[$];
   int           fail_total = 0;

   function automatic logic is_single(input logic [4:0] kind);
      return kind >= NAL_SINGLE_MIN && kind <= NAL_SINGLE_MAX;
   endfunction

   task automatic expect_result(input logic [7:0] b, input logic first, input logic last,
                                input status_type st);
      res_type r;
      r.nal_byte  = b;
      r.nal_first = first;
      r.nal_last  = last;
      r.status    = st;
      nal_expected.push_back(r);
   endtask

   task automatic close_abandoned();
      if (frag_open) begin
         expect_result(8'h00, 1'b0, 1'b0, ST_ABANDON);
         frag_open   = 1'b0;
         frag_ending = 1'b0;
      end
   endtask

   task automatic stap_data(input logic [7:0] b, input logic eop, input logic first);
      left = left - 16'd1;
      expect_result(b, first, left == 16'd0, ST_DATA);
      if (left == 16'd0) begin
         phase = eop ? AT_HEADER : LEN_HIGH;
      end else if (eop) begin
         expect_result(8'h00, 1'b0, 1'b0, ST_OVERRUN);
         phase = AT_HEADER;
      end else begin
         phase = INNER_BODY;
      end
   endtask

   task automatic predict_beat(input logic [7:0] b, input logic eop);
      logic [4:0]  kind;
      logic [16:0] len;
      kind = b[4:0];
      case (phase)
         AT_HEADER: begin
            if (is_single(kind)) begin
               close_abandoned();
               expect_result(b, 1'b1, eop, ST_DATA);
               phase = eop ? AT_HEADER : IN_SINGLE;
            end else if (kind == NAL_STAP_A) begin
               close_abandoned();
               if (eop) expect_result(8'h00, 1'b0, 1'b0, ST_OVERRUN);
               phase = eop ? AT_HEADER : LEN_HIGH;
            end else if (kind == NAL_FU_A) begin
               // indicator alone leaves the fragment untouched
               if (eop) expect_result(8'h00, 1'b0, 1'b0, ST_OVERRUN);
               else nri_bits = b[7:5];
               phase = eop ? AT_HEADER : FU_HEAD;
            end else begin
               close_abandoned();
               expect_result(8'h00, 1'b0, 1'b0, ST_UNSUP);
               phase = eop ? AT_HEADER : FU_BODY;
            end
         end
         IN_SINGLE: begin
            expect_result(b, 1'b0, eop, ST_DATA);
            phase = eop ? AT_HEADER : IN_SINGLE;
         end
         LEN_HIGH: begin
            len_high = b;
            if (eop) expect_result(8'h00, 1'b0, 1'b0, ST_OVERRUN);
            phase = eop ? AT_HEADER : LEN_LOW;
         end
         LEN_LOW: begin
            len = {1'b0, len_high, b};
            if (len > (17'd1 << LENGTH_BITS) - 17'd1) begin
               expect_result(8'h00, 1'b0, 1'b0, ST_OVERRUN);
               phase = eop ? AT_HEADER : FU_BODY;
            end else if (len == 17'd0) begin
               phase = eop ? AT_HEADER : LEN_HIGH;
            end else if (eop) begin
               expect_result(8'h00, 1'b0, 1'b0, ST_OVERRUN);
               phase = AT_HEADER;
            end else begin
               left  = len[15:0];
               phase = INNER_HEAD;
            end
         end
         INNER_HEAD: begin
            if (is_single(kind)) begin
               stap_data(b, eop, 1'b1);
            end else begin
               expect_result(8'h00, 1'b0, 1'b0, ST_UNSUP);
               phase = eop ? AT_HEADER : FU_BODY;
            end
         end
         INNER_BODY: begin
            stap_data(b, eop, 1'b0);
         end
         FU_HEAD: begin
            if (b[7]) begin
               // E bit on a start fragment is ignored
               close_abandoned();
               expect_result({nri_bits, kind}, 1'b1, 1'b0, ST_DATA);
               frag_open   = 1'b1;
               frag_ending = 1'b0;
            end else if (!frag_open) begin
               expect_result(8'h00, 1'b0, 1'b0, ST_ORPHAN);
            end else begin
               frag_ending = b[6];
               if (eop && frag_ending) begin
                  expect_result(8'h00, 1'b0, 1'b1, ST_END);
                  frag_open = 1'b0;
               end
            end
            if (eop) frag_ending = 1'b0;
            phase = eop ? AT_HEADER : FU_BODY;
         end
         default: begin
            // fragment payload, or dropped bytes with no fragment open
            if (frag_open) begin
               expect_result(b, 1'b0, eop && frag_ending, ST_DATA);
               if (eop && frag_ending) frag_open = 1'b0;
            end
            if (eop) begin
               frag_ending = 1'b0;
               phase       = AT_HEADER;
            end
         end
      endcase
   endtask

   always @(posedge clock) begin : monitor
      res_type want;
      if (reset) begin
         phase       = AT_HEADER;
         left        = 16'd0;
         len_high    = 8'd0;
         nri_bits    = 3'd0;
         frag_open   = 1'b0;
         frag_ending = 1'b0;
         nal_expected.delete();
      end else begin
         if (req_ch.valid && req_ch.ready) predict_beat(req_ch.payload_byte, req_ch.packet_end);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (nal_expected.size() == 0) begin
               $error("unexpected beat: status %0d nal_byte %02h", rsp_ch.status,
                      rsp_ch.nal_byte);
               fail_total++;
            end else begin
               want = nal_expected.pop_front();
               if (rsp_ch.nal_byte !== want.nal_byte) begin
                  $error("nal_byte: expected %02h, got %02h", want.nal_byte, rsp_ch.nal_byte);
                  fail_total++;
               end
               if (rsp_ch.nal_first !== want.nal_first) begin
                  $error("nal_first: expected %0b, got %0b", want.nal_first, rsp_ch.nal_first);
                  fail_total++;
               end
               if (rsp_ch.nal_last !== want.nal_last) begin
                  $error("nal_last: expected %0b, got %0b", want.nal_last, rsp_ch.nal_last);
                  fail_total++;
               end
               if (rsp_ch.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                  fail_total++;
               end
            end
         end
      end
      fails       <= fail_total;
      outstanding <= nal_expected.size();
   end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives RTP payload packets into the depacketizer: a short directed set of
// corner packets, then random single NAL, STAP-A and FU-A traffic with some
// broken packets, under changing sender and receiver idle rates.
// ----------------------------------------------------------------------------
module testbench;
   import rtpd_pkg::*;

   localparam int HOLD_CYCLES = 60;
   localparam int STALL_LIMIT = 2000;
   localparam int BEAT_TARGET = 750;

   logic        clock = 1'b0;
   logic        reset;
   int          fails;
   int          outstanding;
   int unsigned req_idle_pct = 22;
   int unsigned rsp_idle_pct = 56;
   bit          hold_go = 1'b0;
   int unsigned quiet_cycles = 0;
   int unsigned beats_sent = 0;
   logic [7:0]  pkt[$];

   rtpd_req_if req_ch();
   rtpd_rsp_if rsp_ch();

   rtp_h264_depacketizer u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   nal_stream_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .fails       (fails),
      .outstanding (outstanding)
   );

   always #1 clock = ~clock;

   // receiver: random stalls, plus a long hold-off counted here
   initial begin : receiver
      bit hold_taken;
      int hold_left;
      hold_taken = 1'b0;
      hold_left  = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left = hold_left - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [7:0] rand_byte();
      logic [7:0] r;
      r = 8'($urandom);
      return r;
   endfunction

   function automatic logic [7:0] hdr(input logic [4:0] kind);
      logic [2:0] nri;
      nri = 3'($urandom);
      return {nri, kind};
   endfunction

   task automatic add_random(input int n);
      repeat (n) pkt.push_back(rand_byte());
   endtask

   task automatic send_beat(input logic [7:0] b, input logic eop);
      if ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < req_idle_pct) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.payload_byte <= b;
      req_ch.packet_end   <= eop;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic send_packet();
      foreach (pkt[i]) send_beat(pkt[i], i == pkt.size() - 1);
      beats_sent += pkt.size();
      pkt.delete();
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic single_nal(input int n);
      logic [4:0] kind;
      kind = 5'($urandom_range(12, 1));
      pkt.push_back(hdr(kind));
      add_random(n);
      send_packet();
   endtask

   task automatic stap_packet();
      int units;
      int len;
      logic [4:0] kind;
      pkt.push_back(hdr(NAL_STAP_A));
      units = $urandom_range(3, 1);
      repeat (units) begin
         len = ($urandom_range(9) == 0) ? 0 : $urandom_range(7, 1);
         pkt.push_back(8'h00);
         pkt.push_back(len[7:0]);
         if (len > 0) begin
            kind = 5'($urandom_range(12, 1));
            pkt.push_back(hdr(kind));
            add_random(len - 1);
         end
      end
      send_packet();
   endtask

   task automatic fu_fragment(input logic [7:0] ind, input logic start, input logic stop,
                              input logic [4:0] kind, input int n);
      logic [7:0] fu_hdr;
      fu_hdr       = rand_byte();
      fu_hdr[7]    = start;
      fu_hdr[6]    = stop;
      fu_hdr[4:0]  = kind;
      pkt.push_back(ind);
      pkt.push_back(fu_hdr);
      add_random(n);
      send_packet();
   endtask

   task automatic fu_sequence();
      logic [7:0] ind;
      logic [4:0] kind;
      logic       e_on_start;
      ind        = hdr(NAL_FU_A);
      kind       = 5'($urandom);
      e_on_start = 1'($urandom);
      fu_fragment(ind, 1'b1, e_on_start, kind, $urandom_range(6));
      repeat ($urandom_range(3)) fu_fragment(ind, 1'b0, 1'b0, kind, $urandom_range(6));
      fu_fragment(ind, 1'b0, 1'b1, kind, $urandom_range(6));
   endtask

   task automatic broken_packet();
      logic [7:0] b;
      logic [4:0] kind;
      case ($urandom_range(6))
         0: add_random($urandom_range(5, 1));
         1: begin
            b    = rand_byte();
            b[7] = 1'b0;
            pkt.push_back(hdr(NAL_FU_A));
            pkt.push_back(b);
            add_random($urandom_range(3));
         end
         2: pkt.push_back(hdr(NAL_FU_A));
         3: begin
            kind = 5'($urandom_range(12, 1));
            pkt.push_back(hdr(NAL_STAP_A));
            add_random(2);
            pkt.push_back(hdr(kind));
            add_random($urandom_range(2));
         end
         4: begin
            b    = rand_byte();
            b[7] = 1'b1;
            pkt.push_back(hdr(NAL_FU_A));
            pkt.push_back(b);
            add_random($urandom_range(4));
         end
         5: begin
            kind = 5'($urandom);
            while ((kind >= NAL_SINGLE_MIN && kind <= NAL_SINGLE_MAX) ||
                   kind == NAL_STAP_A || kind == NAL_FU_A) kind = 5'($urandom);
            pkt.push_back(hdr(kind));
            add_random($urandom_range(3));
         end
         default: begin
            kind = 5'($urandom);
            while (kind >= NAL_SINGLE_MIN && kind <= NAL_SINGLE_MAX) kind = 5'($urandom);
            pkt.push_back(hdr(NAL_STAP_A));
            pkt.push_back(8'h00);
            pkt.push_back(8'h03);
            pkt.push_back(hdr(kind));
            add_random(2);
         end
      endcase
      send_packet();
   endtask

   initial begin
      int pick;
      bit held;
      bit drained;
      held    = 1'b0;
      drained = 1'b0;
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.payload_byte <= 8'h00;
      req_ch.packet_end   <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // single NAL extremes and unsupported header types
      pkt = '{8'h01};                              send_packet();
      pkt = '{8'hEC, 8'h00, 8'hFF};                send_packet();
      pkt = '{8'h00, 8'h55};                       send_packet();
      pkt = '{8'h1F};                              send_packet();
      // STAP-A: zero length, inner NALs, bad inner type, truncations, huge length
      pkt = '{8'h78, 8'h00, 8'h00, 8'h00, 8'h02, 8'h65, 8'hAA, 8'h00, 8'h01, 8'h01};
      send_packet();
      pkt = '{8'h18, 8'h00, 8'h01, 8'h1C};         send_packet();
      pkt = '{8'h18};                              send_packet();
      pkt = '{8'h18, 8'h00};                       send_packet();
      pkt = '{8'h18, 8'h00, 8'h05};                send_packet();
      pkt = '{8'h18, 8'hFF, 8'hFF, 8'h41, 8'h12};  send_packet();
      // FU-A: indicator alone, orphan, E on start, bare end, abandonments
      pkt = '{8'h7C};                              send_packet();
      pkt = '{8'h7C, 8'h05, 8'h33};                send_packet();
      pkt = '{8'h7C, 8'hC5, 8'h11};                send_packet();
      pkt = '{8'h7C, 8'h05, 8'h22};                send_packet();
      pkt = '{8'h7C, 8'h45, 8'hEE};                send_packet();
      pkt = '{8'hFC, 8'h81};                       send_packet();
      pkt = '{8'h7C, 8'h45};                       send_packet();
      pkt = '{8'hFC, 8'h81};                       send_packet();
      pkt = '{8'h09};                              send_packet();
      pkt = '{8'h5C, 8'h9F, 8'h01};                send_packet();
      pkt = '{8'h3C, 8'h80};                       send_packet();
      pkt = '{8'h1E};                              send_packet();

      while (beats_sent < BEAT_TARGET) begin
         if (beats_sent >= 500) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else if (beats_sent >= 250) begin
            req_idle_pct = 56;
            rsp_idle_pct = 22;
         end
         if (!held && beats_sent >= 100) begin
            held    = 1'b1;
            hold_go = 1'b1;
            single_nal(24);
         end
         if (!drained && beats_sent >= 400) begin
            drained = 1'b1;
            wait_drained();
         end
         pick = $urandom_range(99);
         if (pick < 30) single_nal($urandom_range(10));
         else if (pick < 50) stap_packet();
         else if (pick < 85) fu_sequence();
         else broken_packet();
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (fails == 0 && outstanding == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/rtpd_pkg.sv
rtl/rtpd_req_if.sv
rtl/rtpd_rsp_if.sv
rtl/rtpd_front.sv
rtl/rtpd_queue.sv
rtl/rtpd_back.sv
rtl/rtp_h264_depacketizer.sv
rtl/rtpd_checker.sv
verif/nal_stream_checker.sv
verif/testbench.sv
